>>> rtl/tlc_pkg.sv
// Shared types, constants and helper functions for the touch lamp color controller.
// No dependencies; every other file in rtl but tlc_stream_if imports this package.
package tlc_pkg;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned COLOR_W    = 3 * CH_W;
  localparam int unsigned TIDX_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CNT_W-1:0]   CNT_MAX = '1;

  localparam logic [CNT_W-1:0]   POLL_TICKS_RST     = 16'd10;
  localparam logic [CNT_W-1:0]   IGNORE_TICKS_RST   = 16'd500;
  localparam logic [CNT_W-1:0]   HOLD_TICKS_RST     = 16'd100;
  localparam logic [CNT_W-1:0]   FADE_TICKS_RST     = 16'd10;
  localparam logic [COLOR_W-1:0] SHUTDOWN_COLOR_RST = 24'hFF0000;
  localparam logic [COLOR_W-1:0] INITIAL_COLOR_RST  = 24'hFFFFFF;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_TICKS     = 3'd0,
    REG_IGNORE_TICKS   = 3'd1,
    REG_HOLD_TICKS     = 3'd2,
    REG_FADE_TICKS     = 3'd3,
    REG_SHUTDOWN_COLOR = 3'd4,
    REG_INITIAL_COLOR  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0]   poll_ticks;
    logic [CNT_W-1:0]   ignore_ticks;
    logic [CNT_W-1:0]   hold_ticks;
    logic [CNT_W-1:0]   fade_ticks;
    logic [COLOR_W-1:0] shutdown_color;
    logic [COLOR_W-1:0] initial_color;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic               up_level;
    logic               down_level;
    logic               handle_level;
    logic [TIDX_W-1:0]  table_index;
    logic [COLOR_W-1:0] table_color;
  } tlc_in_t;

  typedef struct packed {
    logic [CH_W-1:0]    red_level;
    logic [CH_W-1:0]    green_level;
    logic [CH_W-1:0]    blue_level;
    logic               led_power;
    logic               sensor_power;
    logic               asleep;
    logic [COLOR_W-1:0] beacon_color;
    logic               beacon_enable;
  } tlc_out_t;

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

  // move one channel one step toward its target
  function automatic logic [CH_W-1:0] fade_channel(input logic [CH_W-1:0] s,
                                                   input logic [CH_W-1:0] t);
    logic [CH_W-1:0] r;
    r = s;
    if (t < s) begin
      r = s - 1'b1;
    end else if (t > s) begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/tlc_stream_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
// Depends on nothing; payload types come from tlc_pkg at instantiation.
interface tlc_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tlc_color_table.sv
// Color table memory: one write port, two read ports with registered data.
// A write in the same cycle as a read of that entry is passed to the read data.
module tlc_color_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [tlc_pkg::COLOR_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_a_i,
  input  logic [AW-1:0]               raddr_b_i,
  output logic [tlc_pkg::COLOR_W-1:0] rdata_a_o,
  output logic [tlc_pkg::COLOR_W-1:0] rdata_b_o
);
  import tlc_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_a_q;
  logic [COLOR_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= (we_i && waddr_i == raddr_a_i) ? wdata_i : mem[raddr_a_i];
    rdata_b_q <= (we_i && waddr_i == raddr_b_i) ? wdata_i : mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> rtl/tlc_core.sv
// Lamp state and per-word step logic: pad polling, hold stepping, fading, sleep.
// Holds the configuration registers; uses tlc_pkg and the table neighbor reads.
module tlc_core #(
  parameter int unsigned COLOR_ENTRIES = 64,
  parameter int unsigned IDX_W         = $clog2(COLOR_ENTRIES)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  tlc_pkg::tlc_in_t               word_i,
  input  logic [tlc_pkg::COLOR_W-1:0]    nb_up_i,
  input  logic [tlc_pkg::COLOR_W-1:0]    nb_dn_i,
  input  logic                           cfg_we_i,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [IDX_W-1:0]               rd_addr_up_o,
  output logic [IDX_W-1:0]               rd_addr_dn_o,
  output tlc_pkg::tlc_out_t              result_o
);
  import tlc_pkg::*;

  cfg_t               cfg_q;
  logic               up_q, down_q, handle_q, both_q;
  logic               up_d, down_d, handle_d, both_d;
  logic [CNT_W-1:0]   poll_cnt_q, poll_cnt_d, hold_cnt_q, hold_cnt_d;
  logic [CNT_W-1:0]   fade_cnt_q, fade_cnt_d, poll_period_q, poll_period_d;
  logic [COLOR_W-1:0] target_q, target_d, shown_q, shown_d, kept_q, kept_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               pend_q, pend_d, sleeping_q, sleeping_d;
  logic               led_q, led_d, kept_rst_q, kept_rst_d;
  logic               wr_poll, wr_initial;

  assign wr_poll    = cfg_we_i && (cfg_index_i == REG_POLL_TICKS);
  assign wr_initial = cfg_we_i && (cfg_index_i == REG_INITIAL_COLOR);

  always_comb begin
    up_d          = up_q;
    down_d        = down_q;
    handle_d      = handle_q;
    both_d        = both_q;
    poll_cnt_d    = poll_cnt_q;
    hold_cnt_d    = hold_cnt_q;
    fade_cnt_d    = fade_cnt_q;
    poll_period_d = poll_period_q;
    target_d      = target_q;
    shown_d       = shown_q;
    kept_d        = kept_q;
    idx_d         = idx_q;
    pend_d        = pend_q;
    sleeping_d    = sleeping_q;
    led_d         = led_q;
    kept_rst_d    = kept_rst_q;

    if (fire_i && word_i.mode == MODE_TICK) begin
      if (sleeping_q) begin
        if (word_i.handle_level) begin
          sleeping_d = 1'b0;
          handle_d   = 1'b1;
          target_d   = kept_q;
          pend_d     = 1'b0;
          led_d      = 1'b1;
        end
      end else begin
        poll_cnt_d = count_up(poll_cnt_q);
        hold_cnt_d = count_up(hold_cnt_q);
        fade_cnt_d = count_up(fade_cnt_q);

        if (poll_cnt_d >= poll_period_q) begin
          poll_cnt_d    = '0;
          poll_period_d = cfg_q.poll_ticks;

          if (!up_q && word_i.up_level) begin
            up_d = 1'b1;
            if (down_q) begin
              both_d        = 1'b1;
              target_d      = cfg_q.shutdown_color;
              poll_period_d = cfg_q.ignore_ticks;
            end else begin
              hold_cnt_d = '0;
            end
          end else if (up_q && !word_i.up_level) begin
            up_d   = 1'b0;
            both_d = 1'b0;
          end

          if (!down_q && word_i.down_level) begin
            down_d = 1'b1;
            if (up_d) begin
              both_d        = 1'b1;
              target_d      = cfg_q.shutdown_color;
              poll_period_d = cfg_q.ignore_ticks;
            end else begin
              hold_cnt_d = '0;
            end
          end else if (down_q && !word_i.down_level) begin
            down_d = 1'b0;
            both_d = 1'b0;
          end

          if (!handle_q && word_i.handle_level) begin
            handle_d = 1'b1;
            target_d = kept_q;
            pend_d   = 1'b0;
            led_d    = 1'b1;
          end else if (handle_q && !word_i.handle_level) begin
            handle_d   = 1'b0;
            kept_d     = target_d;
            kept_rst_d = 1'b0;
            target_d   = '0;
            pend_d     = 1'b1;
          end

          // step the index first, then load the neighbor color read last cycle
          if (down_d && !both_d && hold_cnt_d >= cfg_q.hold_ticks) begin
            hold_cnt_d = '0;
            if (idx_q != '0) begin
              idx_d    = idx_q - 1'b1;
              target_d = nb_dn_i;
            end
          end else if (up_d && !both_d && hold_cnt_d >= cfg_q.hold_ticks) begin
            hold_cnt_d = '0;
            if (idx_q != IDX_W'(COLOR_ENTRIES - 1)) begin
              idx_d    = idx_q + 1'b1;
              target_d = nb_up_i;
            end
          end
        end

        if (fade_cnt_d >= cfg_q.fade_ticks) begin
          fade_cnt_d = '0;
          shown_d = {fade_channel(shown_q[23:16], target_d[23:16]),
                     fade_channel(shown_q[15:8],  target_d[15:8]),
                     fade_channel(shown_q[7:0],   target_d[7:0])};
        end

        if (pend_d && shown_d == '0) begin
          sleeping_d = 1'b1;
          led_d      = 1'b0;
        end
      end
    end
  end

  // fetch the neighbors of the index that the next word will see
  assign rd_addr_up_o = idx_d + 1'b1;
  assign rd_addr_dn_o = idx_d - 1'b1;

  always_comb begin
    result_o.red_level     = shown_d[23:16];
    result_o.green_level   = shown_d[15:8];
    result_o.blue_level    = shown_d[7:0];
    result_o.led_power     = led_d;
    result_o.sensor_power  = !pend_d;
    result_o.asleep        = sleeping_d;
    result_o.beacon_color  = (target_d == cfg_q.shutdown_color) ? '0 : target_d;
    result_o.beacon_enable = !pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_ticks     <= POLL_TICKS_RST;
      cfg_q.ignore_ticks   <= IGNORE_TICKS_RST;
      cfg_q.hold_ticks     <= HOLD_TICKS_RST;
      cfg_q.fade_ticks     <= FADE_TICKS_RST;
      cfg_q.shutdown_color <= SHUTDOWN_COLOR_RST;
      cfg_q.initial_color  <= INITIAL_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_POLL_TICKS:     cfg_q.poll_ticks     <= cfg_data_i[CNT_W-1:0];
        REG_IGNORE_TICKS:   cfg_q.ignore_ticks   <= cfg_data_i[CNT_W-1:0];
        REG_HOLD_TICKS:     cfg_q.hold_ticks     <= cfg_data_i[CNT_W-1:0];
        REG_FADE_TICKS:     cfg_q.fade_ticks     <= cfg_data_i[CNT_W-1:0];
        REG_SHUTDOWN_COLOR: cfg_q.shutdown_color <= cfg_data_i[COLOR_W-1:0];
        REG_INITIAL_COLOR:  cfg_q.initial_color  <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q          <= 1'b0;
      down_q        <= 1'b0;
      handle_q      <= 1'b0;
      both_q        <= 1'b0;
      poll_cnt_q    <= '0;
      hold_cnt_q    <= '0;
      fade_cnt_q    <= '0;
      poll_period_q <= POLL_TICKS_RST;
      target_q      <= '0;
      shown_q       <= '0;
      kept_q        <= INITIAL_COLOR_RST;
      idx_q         <= '0;
      pend_q        <= 1'b1;
      sleeping_q    <= 1'b0;
      led_q         <= 1'b0;
      kept_rst_q    <= 1'b1;
    end else begin
      up_q          <= up_d;
      down_q        <= down_d;
      handle_q      <= handle_d;
      both_q        <= both_d;
      poll_cnt_q    <= poll_cnt_d;
      hold_cnt_q    <= hold_cnt_d;
      fade_cnt_q    <= fade_cnt_d;
      poll_period_q <= wr_poll ? cfg_data_i[CNT_W-1:0] : poll_period_d;
      target_q      <= target_d;
      shown_q       <= shown_d;
      kept_q        <= (wr_initial && kept_rst_q) ? cfg_data_i[COLOR_W-1:0] : kept_d;
      idx_q         <= idx_d;
      pend_q        <= pend_d;
      sleeping_q    <= sleeping_d;
      led_q         <= led_d;
      kept_rst_q    <= kept_rst_d;
    end
  end

  // a second pad touch always marks both pads, so no hold step runs while both are held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (up_q && down_q) |-> both_q)
    else $error("both pads touched without both flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sleeping_q |-> (shown_q == '0 && pend_q && !led_q))
    else $error("asleep with lit LEDs or no pending sleep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(idx_q) |-> (idx_q == $past(idx_q) + 1'b1 || idx_q == $past(idx_q) - 1'b1))
    else $error("color index moved by more than one step");

endmodule

>>> rtl/touch_lamp_color_controller.sv
// Top level of the touch lamp color controller: input and result registers,
// color table and step core. Uses tlc_pkg, tlc_stream_if, tlc_color_table, tlc_core.
//
// Each input word is either a one-millisecond tick carrying the up, down and handle
// pad levels, or a write of one color table entry. Every word yields exactly one
// result word showing the lamp state after it. The block takes one word per clock
// cycle while the result side keeps taking results. A word passes through the input
// register, and its result is then offered from the result register. A held result
// does not block the input side until both registers are full. Hold steps load the
// table colors next to the current index, which the table's two read ports fetch
// ahead into registered data. The table has no reset, so entries must be written
// before the index reaches them. The user must make configuration writes only while
// no word is in flight; the block itself does not enforce this.
module touch_lamp_color_controller #(
  parameter int unsigned COLOR_ENTRIES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tlc_stream_if.sink                     in_i,
  tlc_stream_if.source                   res_o,
  input  logic                           cfg_we_i,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tlc_pkg::*;

  localparam int unsigned IDX_W = $clog2(COLOR_ENTRIES);

  logic             in_valid_q, in_valid_d;
  tlc_in_t          in_word_q;
  logic             out_valid_q, out_valid_d;
  tlc_out_t         out_word_q;
  tlc_out_t         result;
  logic             fire;
  logic             tbl_we;
  logic [IDX_W-1:0] rd_addr_up, rd_addr_dn;
  logic [COLOR_W-1:0] nb_up, nb_dn;

  // advance the held word when the result register is free or being drained
  assign fire        = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_i.ready  = !in_valid_q || fire;
  assign in_valid_d  = (in_i.valid && in_i.ready) || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && !res_o.ready);

  assign tbl_we = fire && (in_word_q.mode == MODE_WRITE)
                  && (32'(in_word_q.table_index) < COLOR_ENTRIES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_word_q <= in_i.data;
    end
    if (fire) begin
      out_word_q <= result;
    end
  end

  tlc_color_table #(
    .DEPTH (COLOR_ENTRIES),
    .AW    (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (IDX_W'(in_word_q.table_index)),
    .wdata_i   (in_word_q.table_color),
    .raddr_a_i (rd_addr_up),
    .raddr_b_i (rd_addr_dn),
    .rdata_a_o (nb_up),
    .rdata_b_o (nb_dn)
  );

  tlc_core #(
    .COLOR_ENTRIES (COLOR_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .word_i       (in_word_q),
    .nb_up_i      (nb_up),
    .nb_dn_i      (nb_dn),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .rd_addr_up_o (rd_addr_up),
    .rd_addr_dn_o (rd_addr_dn),
    .result_o     (result)
  );

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_word_q;

endmodule

>>> bench/touch_lamp_color_controller_test.sv
`timescale 1ns / 1ps
// Self-checking bench for touch_lamp_color_controller: a scoreboard class predicts the
// lamp state after every accepted word and checks each result word against it.
// Depends on tlc_pkg, tlc_stream_if and the RTL of the controller.
module touch_lamp_color_controller_test;
  import tlc_pkg::*;

  localparam int unsigned PALETTE_SIZE = 64;
  localparam int unsigned LIMIT_NS     = 5_000_000;

  class lamp_scoreboard;
    logic [CNT_W-1:0]   poll_ticks, ignore_ticks, hold_ticks, fade_ticks;
    logic [COLOR_W-1:0] shutdown_color, initial_color;
    bit                 up_on, down_on, handle_on, both_on;
    logic [CNT_W-1:0]   poll_cnt, poll_period, hold_cnt, fade_cnt;
    logic [COLOR_W-1:0] target_color, shown_color, kept_color;
    logic [TIDX_W-1:0]  color_index;
    bit                 sleep_pending, sleeping, led_on, kept_initial;
    logic [COLOR_W-1:0] palette [PALETTE_SIZE];
    tlc_out_t           lamp_due[$];
    int                 errors;

    function new();
      poll_ticks     = POLL_TICKS_RST;
      ignore_ticks   = IGNORE_TICKS_RST;
      hold_ticks     = HOLD_TICKS_RST;
      fade_ticks     = FADE_TICKS_RST;
      shutdown_color = SHUTDOWN_COLOR_RST;
      initial_color  = INITIAL_COLOR_RST;
      up_on          = 1'b0;
      down_on        = 1'b0;
      handle_on      = 1'b0;
      both_on        = 1'b0;
      poll_cnt       = '0;
      poll_period    = POLL_TICKS_RST;
      hold_cnt       = '0;
      fade_cnt       = '0;
      target_color   = '0;
      shown_color    = '0;
      kept_color     = INITIAL_COLOR_RST;
      color_index    = '0;
      sleep_pending  = 1'b1;
      sleeping       = 1'b0;
      led_on         = 1'b0;
      kept_initial   = 1'b1;
      errors         = 0;
    endfunction

    function void write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_POLL_TICKS: begin
          poll_ticks  = v[CNT_W-1:0];
          poll_period = v[CNT_W-1:0];
        end
        REG_IGNORE_TICKS:   ignore_ticks   = v[CNT_W-1:0];
        REG_HOLD_TICKS:     hold_ticks     = v[CNT_W-1:0];
        REG_FADE_TICKS:     fade_ticks     = v[CNT_W-1:0];
        REG_SHUTDOWN_COLOR: shutdown_color = v[COLOR_W-1:0];
        REG_INITIAL_COLOR: begin
          initial_color = v[COLOR_W-1:0];
          if (kept_initial) kept_color = v[COLOR_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function logic [CH_W-1:0] step_toward(logic [CH_W-1:0] s, logic [CH_W-1:0] t);
      if (t < s) return s - 1'b1;
      if (t > s) return s + 1'b1;
      return s;
    endfunction

    function void wake_lamp();
      target_color  = kept_color;
      sleep_pending = 1'b0;
      led_on        = 1'b1;
    endfunction

    // one pad poll: edges of up, down and handle, then the hold steps
    function void sample_pads(bit up, bit down, bit handle);
      poll_period = poll_ticks;
      if (!up_on && up) begin
        up_on = 1'b1;
        if (down_on) begin
          both_on      = 1'b1;
          target_color = shutdown_color;
          poll_period  = ignore_ticks;
        end else begin
          hold_cnt = '0;
        end
      end else if (up_on && !up) begin
        up_on   = 1'b0;
        both_on = 1'b0;
      end
      if (!down_on && down) begin
        down_on = 1'b1;
        if (up_on) begin
          both_on      = 1'b1;
          target_color = shutdown_color;
          poll_period  = ignore_ticks;
        end else begin
          hold_cnt = '0;
        end
      end else if (down_on && !down) begin
        down_on = 1'b0;
        both_on = 1'b0;
      end
      if (!handle_on && handle) begin
        handle_on = 1'b1;
        wake_lamp();
      end else if (handle_on && !handle) begin
        handle_on     = 1'b0;
        kept_color    = target_color;
        kept_initial  = 1'b0;
        target_color  = '0;
        sleep_pending = 1'b1;
      end
      // move the index first, then load its color
      if (down_on && !both_on && hold_cnt >= hold_ticks) begin
        hold_cnt = '0;
        if (color_index != 0) begin
          color_index--;
          target_color = palette[color_index];
        end
      end
      if (up_on && !both_on && hold_cnt >= hold_ticks) begin
        hold_cnt = '0;
        if (color_index < PALETTE_SIZE - 1) begin
          color_index++;
          target_color = palette[color_index];
        end
      end
    endfunction

    function void note_word(tlc_in_t w);
      tlc_out_t o;
      if (w.mode == MODE_WRITE) begin
        palette[w.table_index] = w.table_color;
      end else if (sleeping) begin
        // only a handle touch does anything while asleep
        if (w.handle_level) begin
          sleeping  = 1'b0;
          handle_on = 1'b1;
          wake_lamp();
        end
      end else begin
        poll_cnt = bump(poll_cnt);
        hold_cnt = bump(hold_cnt);
        fade_cnt = bump(fade_cnt);
        if (poll_cnt >= poll_period) begin
          poll_cnt = '0;
          sample_pads(w.up_level, w.down_level, w.handle_level);
        end
        if (fade_cnt >= fade_ticks) begin
          fade_cnt    = '0;
          shown_color = {step_toward(shown_color[23:16], target_color[23:16]),
                         step_toward(shown_color[15:8], target_color[15:8]),
                         step_toward(shown_color[7:0], target_color[7:0])};
        end
        if (sleep_pending && shown_color == 0) begin
          sleeping = 1'b1;
          led_on   = 1'b0;
        end
      end
      o.red_level     = shown_color[23:16];
      o.green_level   = shown_color[15:8];
      o.blue_level    = shown_color[7:0];
      o.led_power     = led_on;
      o.sensor_power  = !sleep_pending;
      o.asleep        = sleeping;
      o.beacon_color  = (target_color == shutdown_color) ? '0 : target_color;
      o.beacon_enable = !sleep_pending;
      lamp_due.push_back(o);
    endfunction

    function void check_field(string name, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(tlc_out_t r);
      tlc_out_t e;
      if (lamp_due.size() == 0) begin
        errors++;
        $display("%0t: result word %0h with nothing expected", $time, r);
        return;
      end
      e = lamp_due.pop_front();
      check_field("red_level", e.red_level, r.red_level);
      check_field("green_level", e.green_level, r.green_level);
      check_field("blue_level", e.blue_level, r.blue_level);
      check_field("led_power", e.led_power, r.led_power);
      check_field("sensor_power", e.sensor_power, r.sensor_power);
      check_field("asleep", e.asleep, r.asleep);
      check_field("beacon_color", e.beacon_color, r.beacon_color);
      check_field("beacon_enable", e.beacon_enable, r.beacon_enable);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tlc_stream_if #(.word_t(tlc_in_t))  word_in ();
  tlc_stream_if #(.word_t(tlc_out_t)) lamp_out ();

  touch_lamp_color_controller #(
    .COLOR_ENTRIES(PALETTE_SIZE)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (word_in),
    .res_o       (lamp_out),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  lamp_scoreboard lamp_sb;
  bit             idle_on      = 1'b1;
  bit             hold_off_req = 1'b0;
  bit             pad_up       = 1'b0;
  bit             pad_down     = 1'b0;
  bit             pad_handle   = 1'b0;
  bit             long_run     = 1'b0;
  int             run_left     = 0;

  always #5 clk_i = ~clk_i;

  // result side: random stalls while idle_on is set, plus one long hold-off on each request
  initial begin
    lamp_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        lamp_out.ready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end
      lamp_out.ready <= !idle_on || ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && lamp_out.valid && lamp_out.ready) lamp_sb.check_word(lamp_out.data);
  end

  initial begin
    #(LIMIT_NS);
    $display("touch_lamp_color_controller_test: errors");
    $finish;
  end

  function automatic logic [COLOR_W-1:0] pick_color();
    logic [CH_W-1:0] r, g, b;
    if ($urandom_range(0, 99) >= 70) return COLOR_W'($urandom);
    r = CH_W'($urandom_range(0, 12));
    g = CH_W'($urandom_range(0, 12));
    b = CH_W'($urandom_range(0, 12));
    return {r, g, b};
  endfunction

  function automatic tlc_in_t tick_word(bit up, bit down, bit handle);
    tlc_in_t w;
    w.mode         = MODE_TICK;
    w.up_level     = up;
    w.down_level   = down;
    w.handle_level = handle;
    w.table_index  = TIDX_W'($urandom);
    w.table_color  = COLOR_W'($urandom);
    return w;
  endfunction

  function automatic tlc_in_t table_word(logic [TIDX_W-1:0] idx, logic [COLOR_W-1:0] color);
    tlc_in_t w;
    w.mode         = MODE_WRITE;
    w.up_level     = 1'($urandom);
    w.down_level   = 1'($urandom);
    w.handle_level = 1'($urandom);
    w.table_index  = idx;
    w.table_color  = color;
    return w;
  endfunction

  // mostly held pad patterns, some table writes and some raw noise
  function automatic tlc_in_t next_word();
    logic [63:0] noise;
    int          roll;
    roll  = $urandom_range(0, 99);
    noise = {$urandom, $urandom};
    if (roll < 8) return table_word(TIDX_W'($urandom_range(0, PALETTE_SIZE - 1)), pick_color());
    if (roll < 12) return noise[$bits(tlc_in_t)-1:0];
    if (run_left == 0) begin
      long_run = ($urandom_range(0, 99) < 10);
      pad_up   = 1'($urandom_range(0, 1));
      if (long_run) begin
        // long single-pad press to walk the index into its limits
        pad_down   = !pad_up;
        pad_handle = 1'b1;
        run_left   = $urandom_range(64, 90);
      end else begin
        pad_down = 1'($urandom_range(0, 1));
        run_left = $urandom_range(1, 12);
      end
    end
    run_left--;
    if (!long_run && $urandom_range(0, 99) < 4) pad_handle = !pad_handle;
    return tick_word(pad_up, pad_down, pad_handle);
  endfunction

  task automatic send_word(tlc_in_t w);
    while (idle_on && $urandom_range(0, 99) < 20) begin
      word_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    word_in.valid <= 1'b1;
    word_in.data  <= w;
    @(posedge clk_i);
    while (!word_in.ready) @(posedge clk_i);
    lamp_sb.note_word(w);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_word(next_word());
  endtask

  task automatic drain_results();
    word_in.valid <= 1'b0;
    while (lamp_sb.lamp_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk_i);
    lamp_sb.write_reg(r, v);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [CNT_W-1:0] poll, logic [CNT_W-1:0] ignore,
                            logic [CNT_W-1:0] hold, logic [CNT_W-1:0] fade,
                            logic [COLOR_W-1:0] shutdown, logic [COLOR_W-1:0] initial_c);
    drain_results();
    write_reg(REG_POLL_TICKS, CFG_DATA_W'(poll));
    write_reg(REG_IGNORE_TICKS, CFG_DATA_W'(ignore));
    write_reg(REG_HOLD_TICKS, CFG_DATA_W'(hold));
    write_reg(REG_FADE_TICKS, CFG_DATA_W'(fade));
    write_reg(REG_SHUTDOWN_COLOR, shutdown);
    write_reg(REG_INITIAL_COLOR, initial_c);
  endtask

  initial begin
    lamp_sb = new();
    rst_ni        <= 1'b0;
    word_in.valid <= 1'b0;
    word_in.data  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_POLL_TICKS;
    cfg_data      <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(16'd1, 16'd4, 16'd2, 16'd1, 24'h0F0000, 24'h030201);
    // fill the whole table so no hold step ever reads an empty entry
    for (int i = 0; i < PALETTE_SIZE; i++) send_word(table_word(TIDX_W'(i), pick_color()));

    send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b1, 1'b1, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b1));
    send_word(table_word(6'd1, 24'h040404));
    send_word(table_word(6'd0, 24'h000000));
    send_word(table_word(6'd63, 24'hFFFFFF));
    send_word(tick_word(1'b1, 1'b0, 1'b1));
    send_word(tick_word(1'b1, 1'b0, 1'b1));
    send_word(tick_word(1'b1, 1'b0, 1'b1));
    send_word(tick_word(1'b0, 1'b1, 1'b1));
    send_word(tick_word(1'b0, 1'b1, 1'b1));
    send_word(tick_word(1'b0, 1'b1, 1'b1));
    send_word(tick_word(1'b0, 1'b1, 1'b1));
    send_word(tick_word(1'b0, 1'b0, 1'b1));
    for (int i = 0; i < 6; i++) send_word(tick_word(1'b0, 1'b0, 1'b0));
    send_word(tick_word(1'b0, 1'b0, 1'b1));
    send_word(tick_word(1'b1, 1'b0, 1'b1));
    send_word(tick_word(1'b1, 1'b1, 1'b1));
    send_word(tick_word(1'b1, 1'b1, 1'b1));
    send_word(tick_word(1'b1, 1'b1, 1'b1));

    // a poll_ticks write here replaces the stretched ignore period
    set_config(16'd1, 16'd3, 16'd1, 16'd1, pick_color(), 24'hFFFFFF);
    hold_off_req = 1'b1;
    send_random(300);

    set_config(16'd0, 16'd0, 16'd0, 16'd0, 24'h000000, 24'h000000);
    send_random(250);

    set_config(16'd2, 16'd9, 16'd3, 16'd1, 24'hFFFFFF, pick_color());
    idle_on = 1'b0;
    send_random(150);
    drain_results();
    idle_on = 1'b1;
    hold_off_req = 1'b1;
    send_random(150);

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, pick_color(), pick_color());
    send_random(60);

    set_config(16'($urandom_range(1, 3)), 16'hFFFF, 16'($urandom_range(0, 4)),
               16'($urandom_range(1, 2)), pick_color(), pick_color());
    send_random(300);

    set_config(16'd1, 16'd2, 16'd1, 16'd1, 24'h000001, 24'h010101);
    send_random(120);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (lamp_sb.errors == 0 && lamp_sb.lamp_due.size() == 0) begin
      $display("touch_lamp_color_controller_test: clean");
    end else begin
      $display("touch_lamp_color_controller_test: errors");
    end
    $finish;
  end

endmodule
